[hw/rtl/sev_pkg.sv]
// Shared types and constants for the Smagorinsky eddy viscosity unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sev_pkg;

  // One root bit per cell; radicand is 63 bits wide.
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned BACK_STAGES  = 2;

  localparam logic [15:0] SMAG_CONSTANT_RESET     = 16'd6554;  // 0.1 in Q0.16
  localparam logic [15:0] FILTER_MULTIPLIER_RESET = 16'd8192;  // 2.0 in Q4.12

  typedef enum logic [0:0] {
    REG_SMAG_CONSTANT     = 1'b0,
    REG_FILTER_MULTIPLIER = 1'b1
  } cfg_reg_t;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic        valid;
    logic [63:0] rem;   // radicand remainder
    logic [63:0] root;  // partial root, scaled
    logic [63:0] d2;    // squared filter width, Q24.40
  } sqrt_stage_t;

endpackage

`default_nettype wire

[hw/rtl/sev_front.sv]
// Front pipeline: input capture, gradient squares, strain sum, filter width.
// Depends on sev_pkg; feeds the first root cell.
`default_nettype none

module sev_front import sev_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [1:0]         dims,
  input  logic signed [23:0] grad_xx,
  input  logic signed [23:0] grad_xy,
  input  logic signed [23:0] grad_xz,
  input  logic signed [23:0] grad_yx,
  input  logic signed [23:0] grad_yy,
  input  logic signed [23:0] grad_yz,
  input  logic signed [23:0] grad_zx,
  input  logic signed [23:0] grad_zy,
  input  logic signed [23:0] grad_zz,
  input  logic [23:0]        len_scale,
  input  logic [31:0]        cm,
  output sqrt_stage_t        dout
);

  // stage a: captured transaction
  logic               a_valid;
  logic [1:0]         a_dims;
  logic signed [23:0] a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz;
  logic [23:0]        a_len;

  // stage b: masked squares, raw filter width
  logic        b_valid;
  logic [46:0] b_dxx, b_dyy, b_dzz;
  logic [48:0] b_oxy, b_oxz, b_oyz;
  logic [55:0] b_fw;

  // stage c: partial sums, rounded filter width
  logic        c_valid;
  logic [48:0] c_diag;
  logic [50:0] c_off;
  logic [31:0] c_d;

  // stage d
  logic        d_valid;
  logic [63:0] d_rem;
  logic [63:0] d_d2;

  logic signed [47:0] sq_xx, sq_yy, sq_zz;
  logic signed [24:0] s_xy, s_xz, s_yz;
  logic signed [49:0] p_xy, p_xz, p_yz;
  logic        en1, en2, en3;
  logic [55:0] fw, fw_rnd;
  logic [50:0] sum;

  always_comb begin
    sq_xx  = 48'(a_xx) * 48'(a_xx);
    sq_yy  = 48'(a_yy) * 48'(a_yy);
    sq_zz  = 48'(a_zz) * 48'(a_zz);
    s_xy   = 25'(a_xy) + 25'(a_yx);
    s_xz   = 25'(a_xz) + 25'(a_zx);
    s_yz   = 25'(a_yz) + 25'(a_zy);
    p_xy   = 50'(s_xy) * 50'(s_xy);
    p_xz   = 50'(s_xz) * 50'(s_xz);
    p_yz   = 50'(s_yz) * 50'(s_yz);
    en1    = (a_dims >= 2'd1);
    en2    = (a_dims >= 2'd2);
    en3    = (a_dims == 2'd3);
    fw     = 56'(cm) * 56'(a_len);
    fw_rnd = b_fw + (56'd1 << 23);
    sum    = 51'({c_diag, 1'b0}) + 51'(c_off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= take;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dims <= dims;
    a_xx   <= grad_xx;
    a_xy   <= grad_xy;
    a_xz   <= grad_xz;
    a_yx   <= grad_yx;
    a_yy   <= grad_yy;
    a_yz   <= grad_yz;
    a_zx   <= grad_zx;
    a_zy   <= grad_zy;
    a_zz   <= grad_zz;
    a_len  <= len_scale;

    b_dxx  <= en1 ? sq_xx[46:0] : '0;
    b_dyy  <= en2 ? sq_yy[46:0] : '0;
    b_dzz  <= en3 ? sq_zz[46:0] : '0;
    b_oxy  <= en2 ? p_xy[48:0] : '0;
    b_oxz  <= en3 ? p_xz[48:0] : '0;
    b_oyz  <= en3 ? p_yz[48:0] : '0;
    b_fw   <= fw;

    c_diag <= 49'(b_dxx) + 49'(b_dyy) + 49'(b_dzz);
    c_off  <= 51'(b_oxy) + 51'(b_oxz) + 51'(b_oyz);
    c_d    <= fw_rnd[55:24];

    d_rem  <= {1'b0, sum, 12'b0};
    d_d2   <= 64'(c_d) * 64'(c_d);
  end

  assign dout = '{valid: d_valid, rem: d_rem, root: 64'd0, d2: d_d2};

endmodule

`default_nettype wire

[hw/rtl/sev_sqrt_cell.sv]
// One cell of the square-root chain: settles one root bit per pass.
// Depends on sev_pkg (stage struct).
`default_nettype none

module sev_sqrt_cell import sev_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  sqrt_stage_t din,
  output sqrt_stage_t dout
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Idx);

  logic        valid_q;
  logic [63:0] rem_q, root_q, d2_q;
  logic [63:0] trial;
  logic        fits;

  assign trial = din.root + Bit;
  assign fits  = (din.rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_q  <= fits ? (din.rem - trial) : din.rem;
    root_q <= fits ? ((din.root >> 1) + Bit) : (din.root >> 1);
    d2_q   <= din.d2;
  end

  assign dout = '{valid: valid_q, rem: rem_q, root: root_q, d2: d2_q};

endmodule

`default_nettype wire

[hw/rtl/sev_back.sv]
// Back pipeline: D^2 * |S| in two 32x32 partial products, rounding, saturation.
// Depends on sev_pkg; takes the last root cell's output.
`default_nettype none

module sev_back import sev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sqrt_stage_t din,
  output logic        done,
  output logic [47:0] eddy_viscosity,
  output logic        saturated
);

  logic        e_valid;
  logic [63:0] e_p0, e_p1;
  logic [95:0] total;
  logic        sat;

  assign total = 96'(e_p0) + {e_p1, 32'd0} + (96'd1 << 33);
  assign sat   = |total[95:82];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      e_valid <= din.valid;
      done    <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_p0           <= 64'(din.d2[31:0]) * 64'(din.root[31:0]);
    e_p1           <= 64'(din.d2[63:32]) * 64'(din.root[31:0]);
    eddy_viscosity <= sat ? '1 : total[81:34];
    saturated      <= sat;
  end

endmodule

`default_nettype wire

[hw/rtl/smagorinsky_eddy_viscosity_unit.sv]
// Top level of the Smagorinsky eddy viscosity unit.
// Depends on sev_pkg, sev_front, sev_sqrt_cell and sev_back.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     start / busy         dims, grad_xx .. grad_zz, len_scale
//   result    done (strobe)        eddy_viscosity (Q24.24), saturated
//   config    cfg_we               cfg_index, cfg_data (16 bits)
//
// One transaction is accepted per clock (start high, busy low); busy is only
// high during reset. Every transaction yields one result: done is raised once it
// has passed the 4 front stages, 32 root cells and 2 back stages. The 32-cell
// square-root chain, one root bit per cell, sets the latency; throughput is
// one point per cycle. The receiver cannot stall.
// Synchronous reset clears all valid bits and loads the register defaults.
`default_nettype none

module smagorinsky_eddy_viscosity_unit import sev_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         dims,
  input  logic signed [23:0] grad_xx,
  input  logic signed [23:0] grad_xy,
  input  logic signed [23:0] grad_xz,
  input  logic signed [23:0] grad_yx,
  input  logic signed [23:0] grad_yy,
  input  logic signed [23:0] grad_yz,
  input  logic signed [23:0] grad_zx,
  input  logic signed [23:0] grad_zy,
  input  logic signed [23:0] grad_zz,
  input  logic [23:0]        len_scale,
  output logic               done,
  output logic [47:0]        eddy_viscosity,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int unsigned Latency = FRONT_STAGES + SQRT_STEPS + BACK_STAGES;

  logic [15:0] smag_constant;
  logic [15:0] filter_multiplier;
  logic [31:0] cm;      // C*m, Q4.28; refreshed every cycle
  logic        take;

  sqrt_stage_t chain [SQRT_STEPS + 1];

  assign busy = rst;
  assign take = start && !busy;

  // Config registers; the user must write only while the pipe is empty, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      smag_constant     <= SMAG_CONSTANT_RESET;
      filter_multiplier <= FILTER_MULTIPLIER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SMAG_CONSTANT:     smag_constant     <= cfg_data;
        REG_FILTER_MULTIPLIER: filter_multiplier <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient product is registered from the config registers and feeds the stage b filter width.
  always_ff @(posedge clk) begin
    cm <= 32'(smag_constant) * 32'(filter_multiplier);
  end

  sev_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .dims      (dims),
    .grad_xx   (grad_xx),
    .grad_xy   (grad_xy),
    .grad_xz   (grad_xz),
    .grad_yx   (grad_yx),
    .grad_yy   (grad_yy),
    .grad_yz   (grad_yz),
    .grad_zx   (grad_zx),
    .grad_zy   (grad_zy),
    .grad_zz   (grad_zz),
    .len_scale (len_scale),
    .cm        (cm),
    .dout      (chain[0])
  );

  // Restoring square root, MSB first: cell k tries bit 2^(62-2k).
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
    sev_sqrt_cell #(
      .Idx (k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[k]),
      .dout (chain[k + 1])
    );
  end

  sev_back u_back (
    .clk            (clk),
    .rst            (rst),
    .din            (chain[SQRT_STEPS]),
    .done           (done),
    .eddy_viscosity (eddy_viscosity),
    .saturated      (saturated)
  );

`ifndef ASSERT_OFF
  // Fixed latency: every strobe traces back to an accepted transaction.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, Latency))
    else $error("result strobe without matching accepted transaction");

  // Clipped results read full scale.
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (eddy_viscosity == 48'hFFFF_FFFF_FFFF))
    else $error("saturated result not at full scale");

  // Zero length scale gives zero filter width, hence zero viscosity.
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (done && $past(take && (len_scale == 24'd0), Latency))
      |-> ((eddy_viscosity == 48'd0) && !saturated))
    else $error("nonzero viscosity for zero length scale");
`endif

endmodule

`default_nettype wire
